/* rtl/core/assert_macros.svh */
// Assertion macros used by the SHA-256 core controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define SHA_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Condition in one cycle implies the property in the next.
`define SHA_CHECK_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* rtl/core/sha256ds_pkg.sv */
// Package for the SHA-256 core: widths, constants, command types and round functions.
`default_nettype none
package sha256ds_pkg;

   localparam int WORD_W  = 32;
   localparam int FILL_W  = 6;
   localparam int MSG_W   = 61;
   localparam int ROUND_W = 6;
   localparam int IDX_W   = 3;
   localparam int BLOCK_W = 512;
   localparam int HASH_N  = 8;

   typedef logic [WORD_W-1:0] word_type;

   localparam logic [FILL_W-1:0]  FILL_LAST  = 6'd63;
   localparam logic [FILL_W-1:0]  FILL_LEN   = 6'd56;
   localparam logic [FILL_W-1:0]  LEN_BYTES  = 6'd8;
   localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
   localparam logic [IDX_W-1:0]   IDX_LAST   = 3'd7;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam logic [1:0] BYTE_DATA = 2'd0;
   localparam logic [1:0] BYTE_MARK = 2'd1;
   localparam logic [1:0] BYTE_ZERO = 2'd2;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam word_type INIT_H [HASH_N] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct packed {
      logic             shift_byte;
      logic [1:0]       byte_sel;
      logic             shift_len;
      logic             count_msg;
      logic             load_work;
      logic             round_step;
      logic             add_hash;
      logic             restart;
      logic [IDX_W-1:0] word_sel;
   } cmd_type;

   typedef struct packed {
      logic [FILL_W-1:0] fill;
      logic              round_last;
   } status_type;

   function automatic word_type rotr(input word_type x, input int unsigned s);
      return (x >> s) | (x << (WORD_W - s));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage
`default_nettype wire

/* rtl/core/sha256ds_if.sv */
// Valid/ready channel interfaces for the request and response words.
`default_nettype none
interface sha256ds_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] data_byte;

   modport source (output valid, output operation, output data_byte, input ready);
   modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface sha256ds_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sha256ds_pkg::WORD_W-1:0] digest_word;
   logic [sha256ds_pkg::IDX_W-1:0]  word_index;
   logic                          last_word;

   modport source (output valid, output digest_word, output word_index, output last_word,
                   input ready);
   modport sink (input valid, input digest_word, input word_index, input last_word,
                 output ready);
endinterface
`default_nettype wire

/* rtl/core/sha256ds_dp.sv */
// SHA-256 datapath: block shift register, message schedule, round logic and hash state.
`default_nettype none
module sha256ds_dp (
   input  wire                            clock,
   input  wire                            reset,
   input  sha256ds_pkg::cmd_type          cmd,
   input  wire  [7:0]                     data_byte,
   output sha256ds_pkg::status_type       status,
   output sha256ds_pkg::word_type         digest_word
);

   logic [sha256ds_pkg::BLOCK_W-1:0] block_ff, block_in;
   logic [sha256ds_pkg::FILL_W-1:0]  fill_ff, fill_in;
   logic [sha256ds_pkg::MSG_W-1:0]   msg_ff, msg_in;
   logic [sha256ds_pkg::ROUND_W-1:0] round_ff, round_in;
   sha256ds_pkg::word_type hash_ff [sha256ds_pkg::HASH_N];
   sha256ds_pkg::word_type hash_in [sha256ds_pkg::HASH_N];
   sha256ds_pkg::word_type work_ff [sha256ds_pkg::HASH_N];
   sha256ds_pkg::word_type work_in [sha256ds_pkg::HASH_N];

   logic [7:0]             byte_val;
   sha256ds_pkg::word_type w0, w1, w9, w14, new_w;
   sha256ds_pkg::word_type ch, maj, t1, t2;

   // schedule window: word 0 sits in the top bits
   assign w0  = block_ff[511:480];
   assign w1  = block_ff[479:448];
   assign w9  = block_ff[223:192];
   assign w14 = block_ff[63:32];

   always_comb begin
      unique case (cmd.byte_sel)
         sha256ds_pkg::BYTE_DATA: byte_val = data_byte;
         sha256ds_pkg::BYTE_MARK: byte_val = sha256ds_pkg::PAD_MARK;
         default:                 byte_val = 8'h00;
      endcase
   end

   always_comb begin
      new_w = sha256ds_pkg::small_sigma1(w14) + w9 + sha256ds_pkg::small_sigma0(w1) + w0;
      ch    = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      maj   = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^
              (work_ff[1] & work_ff[2]);
      t1    = work_ff[7] + sha256ds_pkg::big_sigma1(work_ff[4]) + ch +
              sha256ds_pkg::ROUND_K[round_ff] + w0;
      t2    = sha256ds_pkg::big_sigma0(work_ff[0]) + maj;
   end

   always_comb begin
      block_in = block_ff;
      fill_in  = fill_ff;
      msg_in   = msg_ff;
      round_in = round_ff;
      work_in  = work_ff;
      hash_in  = hash_ff;
      priority if (cmd.shift_byte) begin
         block_in = {block_ff[sha256ds_pkg::BLOCK_W-9:0], byte_val};
         fill_in  = fill_ff + 6'd1;
      end else if (cmd.shift_len) begin
         block_in = {block_ff[sha256ds_pkg::BLOCK_W-65:0], msg_ff, 3'b000};
         fill_in  = fill_ff + sha256ds_pkg::LEN_BYTES;
      end else if (cmd.round_step) begin
         block_in = {block_ff[sha256ds_pkg::BLOCK_W-33:0], new_w};
      end else begin
         block_in = block_ff;
      end
      if (cmd.count_msg) begin
         msg_in = msg_ff + 61'd1;
      end else if (cmd.restart) begin
         msg_in = '0;
      end
      if (cmd.load_work) begin
         round_in = '0;
         work_in  = hash_ff;
      end else if (cmd.round_step) begin
         round_in   = round_ff + 6'd1;
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
      end
      if (cmd.add_hash) begin
         for (int i = 0; i < sha256ds_pkg::HASH_N; i++) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end
      end else if (cmd.restart) begin
         hash_in = sha256ds_pkg::INIT_H;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         msg_ff  <= '0;
         hash_ff <= sha256ds_pkg::INIT_H;
      end else begin
         fill_ff <= fill_in;
         msg_ff  <= msg_in;
         hash_ff <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      round_ff <= round_in;
      work_ff  <= work_in;
   end

   assign status.fill       = fill_ff;
   assign status.round_last = (round_ff == sha256ds_pkg::ROUND_LAST);
   assign digest_word       = hash_ff[cmd.word_sel];

endmodule
`default_nettype wire

/* rtl/core/sha256ds_ctrl.sv */
// SHA-256 controller: absorb, padding, round sequencing and digest word output.
`default_nettype none
`include "assert_macros.svh"
module sha256ds_ctrl (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   input  wire                                 req_operation,
   output logic                                req_ready,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   input  sha256ds_pkg::status_type            status,
   output sha256ds_pkg::cmd_type               cmd,
   output logic [sha256ds_pkg::IDX_W-1:0]      word_index,
   output logic                                last_word
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PAD   = 3'd1;
   localparam logic [2:0] S_ROUND = 3'd2;
   localparam logic [2:0] S_ADD   = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [2:0]                    ret_ff, ret_in;
   logic [sha256ds_pkg::IDX_W-1:0] idx_ff, idx_in;

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = (state_ff == S_EMIT);
   assign word_index = idx_ff;
   assign last_word  = (idx_ff == sha256ds_pkg::IDX_LAST);

   always_comb begin
      cmd          = '0;
      cmd.word_sel = idx_ff;
      state_in     = state_ff;
      ret_in       = ret_ff;
      idx_in       = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.shift_byte = 1'b1;
               if (req_operation == sha256ds_pkg::OP_ABSORB) begin
                  cmd.byte_sel  = sha256ds_pkg::BYTE_DATA;
                  cmd.count_msg = 1'b1;
                  if (status.fill == sha256ds_pkg::FILL_LAST) begin
                     cmd.load_work = 1'b1;
                     state_in      = S_ROUND;
                     ret_in        = S_IDLE;
                  end
               end else begin
                  cmd.byte_sel = sha256ds_pkg::BYTE_MARK;
                  state_in     = S_PAD;
                  if (status.fill == sha256ds_pkg::FILL_LAST) begin
                     cmd.load_work = 1'b1;
                     state_in      = S_ROUND;
                     ret_in        = S_PAD;
                  end
               end
            end
         end
         S_PAD: begin
            if (status.fill == sha256ds_pkg::FILL_LEN) begin
               cmd.shift_len = 1'b1;
               cmd.load_work = 1'b1;
               state_in      = S_ROUND;
               ret_in        = S_EMIT;
            end else begin
               cmd.shift_byte = 1'b1;
               cmd.byte_sel   = sha256ds_pkg::BYTE_ZERO;
               if (status.fill == sha256ds_pkg::FILL_LAST) begin
                  cmd.load_work = 1'b1;
                  state_in      = S_ROUND;
                  ret_in        = S_PAD;
               end
            end
         end
         S_ROUND: begin
            cmd.round_step = 1'b1;
            if (status.round_last) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            cmd.add_hash = 1'b1;
            state_in     = ret_ff;
         end
         S_EMIT: begin
            if (rsp_ready) begin
               if (last_word) begin
                  cmd.restart = 1'b1;
                  idx_in      = '0;
                  state_in    = S_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         idx_ff   <= idx_in;
      end
   end

   `SHA_CHECK(a_one_side_open, !(req_ready && rsp_valid), "req and rsp open together")
   `SHA_CHECK(a_len_at_56, !cmd.shift_len || (status.fill == sha256ds_pkg::FILL_LEN), "length word misplaced")
   `SHA_CHECK_NEXT(a_round_to_add, (state_ff == S_ROUND) && status.round_last, state_ff == S_ADD, "rounds overran")
   `SHA_CHECK_NEXT(a_last_word_idle, rsp_valid && rsp_ready && last_word, (state_ff == S_IDLE) && (idx_ff == '0), "digest not closed")

endmodule
`default_nettype wire

/* rtl/core/sha256_digest_stream_core.sv */
// Absorb word: the 64th byte of a block closes input for the 64 rounds and the hash add.
// No byte is taken while the single round unit compresses a block.
// Finish: pads one byte a cycle up to the length slot, pausing while a full block is compressed,
// then one or two compressions, then eight digest words at one a cycle while the sink is ready.
// Reset is synchronous: initial hash values, zero fill and length; block buffer not cleared.
`default_nettype none
module sha256_digest_stream_core (
   input  wire                   clock,
   input  wire                   reset,
   sha256ds_req_if.sink          req_port,
   sha256ds_rsp_if.source        rsp_port
);

   sha256ds_pkg::cmd_type    cmd;
   sha256ds_pkg::status_type status;

   sha256ds_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_port.valid),
      .req_operation (req_port.operation),
      .req_ready     (req_port.ready),
      .rsp_valid     (rsp_port.valid),
      .rsp_ready     (rsp_port.ready),
      .status        (status),
      .cmd           (cmd),
      .word_index    (rsp_port.word_index),
      .last_word     (rsp_port.last_word)
   );

   sha256ds_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_port.data_byte),
      .status      (status),
      .digest_word (rsp_port.digest_word)
   );

endmodule
`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for sha256_digest_stream_core: random messages, digests predicted in-bench.
`default_nettype none
module testbench;

   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_CYCLES  = 500;
   localparam int TARGET_ITEMS = 370;
   localparam int TAIL_CYCLES  = 200;

   localparam int PHASE_CALM    = 0;
   localparam int PHASE_SENDER  = 1;
   localparam int PHASE_RECEIVE = 2;
   localparam int PHASE_BOTH    = 3;

   typedef struct {
      logic       op;
      logic [7:0] octet;
   } req_word_type;

   typedef struct {
      logic [sha256ds_pkg::WORD_W-1:0] digest;
      logic [sha256ds_pkg::IDX_W-1:0]  index;
      logic                            last;
   } digest_word_type;

   logic clock;
   logic reset;

   sha256ds_req_if req_ch();
   sha256ds_rsp_if rsp_ch();

   sha256_digest_stream_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   req_word_type    pending_items[$];
   digest_word_type pending_digest_words[$];

   // predictor state
   logic [31:0] hash_st [8];
   logic [7:0]  blk_buf [64];
   int unsigned blk_fill;
   logic [60:0] msg_len;

   int unsigned total_items;
   int unsigned accepted;
   int unsigned errors;
   int unsigned words_checked;
   int unsigned messages_done;
   int unsigned bytes_absorbed;
   int unsigned cycle_count;
   int unsigned hold_left;
   bit          hold_done;
   bit          req_taken;

   always #4 clock = ~clock;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int t = 0; t < 16; t++) begin
         w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
      end
      for (int t = 16; t < 64; t++) begin
         w[t] = w[t-16] + w[t-7]
              + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
              + (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10));
      end
      {a, b, c, d, e, f, g, h} = {hash_st[0], hash_st[1], hash_st[2], hash_st[3],
                                  hash_st[4], hash_st[5], hash_st[6], hash_st[7]};
      for (int t = 0; t < 64; t++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + sha256ds_pkg::ROUND_K[t] + w[t];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
      hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
   endtask

   task automatic restart_message();
      for (int k = 0; k < 8; k++) hash_st[k] = sha256ds_pkg::INIT_H[k];
      blk_fill = 0;
      msg_len  = '0;
   endtask

   task automatic sha_absorb(input logic [7:0] octet);
      blk_buf[blk_fill] = octet;
      blk_fill = (blk_fill + 1) % 64;
      msg_len  = msg_len + 1'b1;
      bytes_absorbed++;
      if (blk_fill == 0) compress_block();
   endtask

   task automatic sha_finish();
      logic [63:0] bitlen;
      bitlen = {msg_len, 3'b000};
      blk_buf[blk_fill] = sha256ds_pkg::PAD_MARK;
      blk_fill++;
      if (blk_fill > 56) begin
         while (blk_fill < 64) begin
            blk_buf[blk_fill] = 8'h00;
            blk_fill++;
         end
         compress_block();
         blk_fill = 0;
      end
      while (blk_fill < 56) begin
         blk_buf[blk_fill] = 8'h00;
         blk_fill++;
      end
      for (int k = 0; k < 8; k++) blk_buf[56+k] = bitlen[63-8*k -: 8];
      compress_block();
      for (int k = 0; k < 8; k++) begin
         pending_digest_words.push_back('{hash_st[k], (sha256ds_pkg::IDX_W)'(k), k == 7});
      end
      messages_done++;
      restart_message();
   endtask

   task automatic queue_message(input int len);
      for (int i = 0; i < len; i++) begin
         pending_items.push_back('{sha256ds_pkg::OP_ABSORB, 8'($urandom_range(0, 255))});
      end
      pending_items.push_back('{sha256ds_pkg::OP_FINISH, 8'($urandom_range(0, 255))});
   endtask

   function automatic int idle_pct(input bit sender_side);
      int ph;
      ph = (total_items == 0) ? PHASE_CALM : int'(accepted * 4 / total_items);
      case (ph)
         PHASE_SENDER:  return sender_side ? 78 : 0;
         PHASE_RECEIVE: return sender_side ? 0 : 78;
         PHASE_BOTH:    return 13;
         default:       return 0;
      endcase
   endfunction

   // request driver
   always @(negedge clock) begin
      req_word_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
            nxt = pending_items.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.operation <= nxt.op;
            req_ch.data_byte <= nxt.octet;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, once, early in the calm phase
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end else if (!hold_done && total_items != 0 && accepted >= total_items / 8) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(1'b0));
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      digest_word_type exp_w;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            req_taken = 1'b1;
            accepted++;
            if (req_ch.operation == sha256ds_pkg::OP_FINISH) sha_finish();
            else sha_absorb(req_ch.data_byte);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_digest_words.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected word: digest %h index %0d last %0d",
                           rsp_ch.digest_word, rsp_ch.word_index, rsp_ch.last_word);
            end else begin
               exp_w = pending_digest_words.pop_front();
               words_checked++;
               if (rsp_ch.digest_word !== exp_w.digest || rsp_ch.word_index !== exp_w.index ||
                   rsp_ch.last_word !== exp_w.last) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                              exp_w.digest, exp_w.index, exp_w.last,
                              rsp_ch.digest_word, rsp_ch.word_index, rsp_ch.last_word);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("sha256_digest_stream_core test failed");
         $finish;
      end
   end

   initial begin
      int len;
      int room;
      int boundary [12];
      boundary         = '{1, 54, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
      clock            = 1'b0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.operation = sha256ds_pkg::OP_ABSORB;
      req_ch.data_byte = 8'h00;
      rsp_ch.ready     = 1'b0;
      total_items      = 0;
      accepted         = 0;
      errors           = 0;
      words_checked    = 0;
      messages_done    = 0;
      bytes_absorbed   = 0;
      cycle_count      = 0;
      hold_left        = 0;
      hold_done        = 1'b0;
      req_taken        = 1'b0;
      restart_message();

      // empty messages back to back, then short fixed ones
      pending_items.push_back('{sha256ds_pkg::OP_FINISH, 8'h00});
      pending_items.push_back('{sha256ds_pkg::OP_FINISH, 8'hff});
      pending_items.push_back('{sha256ds_pkg::OP_ABSORB, 8'h61});
      pending_items.push_back('{sha256ds_pkg::OP_ABSORB, 8'h62});
      pending_items.push_back('{sha256ds_pkg::OP_ABSORB, 8'h63});
      pending_items.push_back('{sha256ds_pkg::OP_FINISH, 8'h00});
      pending_items.push_back('{sha256ds_pkg::OP_ABSORB, 8'h00});
      pending_items.push_back('{sha256ds_pkg::OP_ABSORB, 8'hff});
      pending_items.push_back('{sha256ds_pkg::OP_ABSORB, 8'h80});
      pending_items.push_back('{sha256ds_pkg::OP_ABSORB, 8'h7f});
      pending_items.push_back('{sha256ds_pkg::OP_FINISH, 8'h55});

      // random messages, weighted towards the padding boundaries
      while (pending_items.size() < TARGET_ITEMS) begin
         if ($urandom_range(0, 9) < 4) len = boundary[$urandom_range(0, 11)];
         else len = $urandom_range(0, 24);
         room = TARGET_ITEMS - 1 - int'(pending_items.size());
         if (len > room) len = room;
         queue_message(len);
      end
      total_items = pending_items.size();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_items.size() != 0 || req_ch.valid) @(posedge clock);
      while (pending_digest_words.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d words sent: %0d messages, %0d bytes absorbed, %0d digest words checked",
               accepted, messages_done, bytes_absorbed, words_checked);
      $display("idling phases: none, sender, receiver, both; one %0d-cycle receiver hold-off",
               HOLD_CYCLES);
      if (errors == 0 && pending_digest_words.size() == 0) begin
         $display("sha256_digest_stream_core test passed");
      end else begin
         $display("sha256_digest_stream_core test failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl/core
rtl/core/sha256ds_pkg.sv
rtl/core/sha256ds_if.sv
rtl/core/sha256ds_dp.sv
rtl/core/sha256ds_ctrl.sv
rtl/core/sha256_digest_stream_core.sv
sim/testbench.sv
